>>> sv/lpr_pkg.sv
// Package for the LRU page replacement tracker.
// Holds the request, result, recency-stack entry and cell control types.
// Depends on nothing; every other file uses it.
`timescale 1ns / 1ps

package lpr_pkg;

    localparam int MAX_FRAMES = 64;
    localparam int IDX_W      = $clog2(MAX_FRAMES);
    localparam int OCC_W      = $clog2(MAX_FRAMES + 1);
    localparam int ADDR_W     = 32;
    localparam int PAGE_SHIFT = 12;
    localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;
    localparam int CNT_W      = 32;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [OCC_W-1:0]  occ_t;
    typedef logic [PAGE_W-1:0] page_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef struct packed {
        logic [ADDR_W-1:0] byte_address;
        logic              is_write;
    } request_t;

    typedef struct packed {
        logic  hit;
        logic  evicted;
        logic  evicted_dirty;
        page_t evicted_page;
        cnt_t  event_total;
        cnt_t  disk_read_total;
        cnt_t  disk_write_total;
    } result_t;

    typedef struct packed {
        page_t tag;
        logic  dirty;
    } entry_t;

    typedef struct packed {
        logic  capture;
        page_t page;
        occ_t  occ;
        logic  update;
        idx_t  last;
    } cell_ctrl_t;

endpackage

>>> sv/lpr_cell.sv
// One cell of the recency stack: holds one resident page and its dirty mark.
// Compares its tag against a new request and shifts in the entry of the cell above it, or the new entry at the top.
// Depends on lpr_pkg.
`timescale 1ns / 1ps

module lpr_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  lpr_pkg::idx_t      idx,
    input  lpr_pkg::cell_ctrl_t ctrl,
    input  lpr_pkg::entry_t    prev,
    output lpr_pkg::entry_t    entry,
    output logic               match
);
    import lpr_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   match_reg;
    logic   match_next;
    logic   occupied;

    assign occupied = {1'b0, idx} < ctrl.occ;

    always_comb
    begin
        match_next = match_reg;
        if (ctrl.capture)
        begin
            match_next = occupied && (entry_reg.tag == ctrl.page);
        end
        entry_next = entry_reg;
        if (ctrl.update && (idx <= ctrl.last))
        begin
            entry_next = prev;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
            entry_reg <= '0;
        end
        else
        begin
            match_reg <= match_next;
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

>>> sv/lru_page_replacement_tracker_unit.sv
// Top level of the LRU page replacement tracker.
// Builds the recency stack from lpr_cell instances and keeps the counters.
// Depends on lpr_pkg and lpr_cell.
`timescale 1ns / 1ps

// A request (byte address and write flag) is taken at a clock edge where start
// is high and busy is low. The page number is the address bits above bit 11.
// At that edge every cell compares its page against the request at once. In
// the following cycle the stack shifts: the touched or new page enters the top
// cell, the pages above its old place move down one cell, and on a full stack
// the bottom page drops out as the eviction. The result shows on result with
// result_valid high for exactly one cycle; it is registered at the edge that
// ends the shift cycle. Each request passes through the compare cycle and the
// shift cycle of the cell chain; busy is high during the shift cycle only, so
// no new request is taken until the shift is done. The receiver cannot stall
// the result. The frame limit is written through cfg_valid/cfg_ready/cfg_data,
// and cfg_ready is always high; the user must make writes only while no request
// is in flight, and the block itself does not enforce it.
// Reset empties the stack, clears all counters and sets the frame limit to 64.

module lru_page_replacement_tracker_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  lpr_pkg::request_t request,
    output logic              result_valid,
    output lpr_pkg::result_t  result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  lpr_pkg::occ_t     cfg_data
);
    import lpr_pkg::*;

    typedef enum logic {ST_IDLE, ST_UPD} state_t;

    state_t     state_reg;
    occ_t       frames_reg;
    occ_t       occ_reg;
    occ_t       occ_next;
    cnt_t       access_reg;
    cnt_t       access_next;
    cnt_t       miss_reg;
    cnt_t       miss_next;
    cnt_t       wb_reg;
    cnt_t       wb_next;
    page_t      page_reg;
    logic       wr_reg;
    logic       result_valid_reg;
    result_t    result_reg;
    result_t    result_next;

    cell_ctrl_t ctrl;
    entry_t     entries [MAX_FRAMES];
    entry_t     new_entry;
    entry_t     sel;
    logic [MAX_FRAMES-1:0] match;
    idx_t       hit_idx;
    idx_t       last;
    occ_t       limit;
    logic       accept;
    logic       hit;
    logic       evict;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg == ST_UPD);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (frames_reg == '0)
        begin
            limit = occ_t'(1);
        end
        else if (frames_reg > occ_t'(MAX_FRAMES))
        begin
            limit = occ_t'(MAX_FRAMES);
        end
        else
        begin
            limit = frames_reg;
        end
    end

    always_comb
    begin
        hit_idx = '0;
        for (int k = 0; k < MAX_FRAMES; k++)
        begin
            if (match[k])
            begin
                hit_idx = hit_idx | idx_t'(k);
            end
        end
    end

    assign hit   = |match;
    assign evict = !hit && !(occ_reg < limit);

    always_comb
    begin
        if (hit)
        begin
            last = hit_idx;
        end
        else if (occ_reg < limit)
        begin
            last = occ_reg[IDX_W-1:0];
        end
        else
        begin
            last = idx_t'(occ_reg - occ_t'(1));
        end
    end

    always_comb
    begin
        sel = '0;
        for (int k = 0; k < MAX_FRAMES; k++)
        begin
            if (idx_t'(k) == last)
            begin
                sel = sel | entries[k];
            end
        end
    end

    assign new_entry.tag   = page_reg;
    assign new_entry.dirty = wr_reg || (hit && sel.dirty);

    assign ctrl.capture = accept;
    assign ctrl.page    = request.byte_address[ADDR_W-1:PAGE_SHIFT];
    assign ctrl.occ     = occ_reg;
    assign ctrl.update  = (state_reg == ST_UPD);
    assign ctrl.last    = last;

    genvar g;
    generate
        for (g = 0; g < MAX_FRAMES; g++)
        begin : g_cell
            entry_t prev;
            if (g == 0)
            begin : g_top
                assign prev = new_entry;
            end
            else
            begin : g_rest
                assign prev = entries[g-1];
            end
            lpr_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .idx   (idx_t'(g)),
                .ctrl  (ctrl),
                .prev  (prev),
                .entry (entries[g]),
                .match (match[g])
            );
        end
    endgenerate

    always_comb
    begin
        occ_next    = occ_reg;
        access_next = access_reg + cnt_t'(1);
        miss_next   = miss_reg;
        wb_next     = wb_reg;
        if (!hit)
        begin
            miss_next = miss_reg + cnt_t'(1);
            if (!evict)
            begin
                occ_next = occ_reg + occ_t'(1);
            end
            else if (sel.dirty)
            begin
                wb_next = wb_reg + cnt_t'(1);
            end
        end
        result_next.hit              = hit;
        result_next.evicted          = evict;
        result_next.evicted_dirty    = evict && sel.dirty;
        result_next.evicted_page     = evict ? sel.tag : '0;
        result_next.event_total      = access_next;
        result_next.disk_read_total  = miss_next;
        result_next.disk_write_total = wb_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            frames_reg       <= occ_t'(MAX_FRAMES);
            occ_reg          <= '0;
            access_reg       <= '0;
            miss_reg         <= '0;
            wb_reg           <= '0;
            result_valid_reg <= 1'b0;
            page_reg         <= '0;
            wr_reg           <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                frames_reg <= cfg_data;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        page_reg  <= request.byte_address[ADDR_W-1:PAGE_SHIFT];
                        wr_reg    <= request.is_write;
                        state_reg <= ST_UPD;
                    end
                end
                ST_UPD:
                begin
                    occ_reg          <= occ_next;
                    access_reg       <= access_next;
                    miss_reg         <= miss_next;
                    wb_reg           <= wb_next;
                    result_reg       <= result_next;
                    result_valid_reg <= 1'b1;
                    state_reg        <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Resident pages are unique, so at most one cell may report a match.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD) |-> $onehot0(match))
        else $error("more than one cell matched the request page");

    // A result appears only right after a shift cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == ST_UPD))
        else $error("result strobe without a preceding update");

    assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= occ_t'(MAX_FRAMES))
        else $error("occupancy beyond the number of cells");

    // A hit never evicts, and an eviction leaves the occupancy unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.evicted) |-> (!result.hit && $stable(occ_reg)))
        else $error("eviction on a hit or with changing occupancy");

endmodule

>>> dv/lpr_access_checker.sv
// Checker for the LRU page replacement tracker: predicts each access outcome and compares it.
// It watches the request, result and frame-limit channels and counts mismatches.
// Depends on lpr_pkg.
`timescale 1ns / 1ps

module lpr_access_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  lpr_pkg::request_t request,
    input  logic              result_valid,
    input  lpr_pkg::result_t  result,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  lpr_pkg::occ_t     cfg_data,
    input  logic              wrap_up,
    output int                mismatches,
    output int                pending
);

    lpr_pkg::page_t   tag_mem  [lpr_pkg::MAX_FRAMES];
    bit               dirty_mem[lpr_pkg::MAX_FRAMES];
    int               rank_mem [lpr_pkg::MAX_FRAMES];
    int               resident;
    lpr_pkg::cnt_t    access_cnt;
    lpr_pkg::cnt_t    miss_cnt;
    lpr_pkg::cnt_t    writeback_cnt;
    lpr_pkg::occ_t    frame_reg;
    lpr_pkg::result_t pending_outcomes[$];
    int               checked;
    int               hits_seen;
    int               evictions_seen;
    int               writebacks_seen;
    bit               wrapped;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH at result %0d, %s: got %h, expected %h", checked, what, got, want);
        mismatches++;
    endtask

    function automatic void age_down(int above);
        for (int i = 0; i < resident; i++)
            if (rank_mem[i] > above)
                rank_mem[i]--;
    endfunction

    function automatic lpr_pkg::result_t predict_access(lpr_pkg::request_t req);
        lpr_pkg::result_t r;
        lpr_pkg::page_t   pg;
        int               limit;
        int               slot;
        bit               found;
        r = '0;
        pg = req.byte_address[lpr_pkg::ADDR_W-1:lpr_pkg::PAGE_SHIFT];
        slot = 0;
        found = 1'b0;
        for (int i = 0; i < resident; i++)
            if (!found && tag_mem[i] == pg)
            begin
                slot = i;
                found = 1'b1;
            end
        if (found)
        begin
            r.hit = 1'b1;
            age_down(rank_mem[slot]);
            rank_mem[slot] = resident - 1;
            if (req.is_write)
                dirty_mem[slot] = 1'b1;
        end
        else
        begin
            miss_cnt++;
            limit = (frame_reg == 0) ? 1 :
                    ((frame_reg > lpr_pkg::MAX_FRAMES) ? lpr_pkg::MAX_FRAMES : int'(frame_reg));
            if (resident < limit)
            begin
                slot = resident;
                resident++;
            end
            else
            begin
                for (int i = 0; i < resident; i++)
                    if (!found && rank_mem[i] == 0)
                    begin
                        slot = i;
                        found = 1'b1;
                    end
                r.evicted = 1'b1;
                r.evicted_page = tag_mem[slot];
                r.evicted_dirty = dirty_mem[slot];
                if (dirty_mem[slot])
                    writeback_cnt++;
                age_down(0);
            end
            tag_mem[slot] = pg;
            dirty_mem[slot] = req.is_write;
            rank_mem[slot] = resident - 1;
        end
        access_cnt++;
        r.event_total = access_cnt;
        r.disk_read_total = miss_cnt;
        r.disk_write_total = writeback_cnt;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lpr_pkg::result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < lpr_pkg::MAX_FRAMES; i++)
            begin
                tag_mem[i] = '0;
                dirty_mem[i] = 1'b0;
                rank_mem[i] = 0;
            end
            resident = 0;
            access_cnt = '0;
            miss_cnt = '0;
            writeback_cnt = '0;
            frame_reg = lpr_pkg::occ_t'(lpr_pkg::MAX_FRAMES);
            pending_outcomes.delete();
            mismatches = 0;
            checked = 0;
            hits_seen = 0;
            evictions_seen = 0;
            writebacks_seen = 0;
            wrapped = 1'b0;
        end
        else
        begin
            if (result_valid)
            begin
                if (pending_outcomes.size() == 0)
                    report_mismatch("result with nothing expected", 32'd1, 32'd0);
                else
                begin
                    want = pending_outcomes[0];
                    pending_outcomes.delete(0);
                    if (result.hit !== want.hit)
                        report_mismatch("hit", 32'(result.hit), 32'(want.hit));
                    if (result.evicted !== want.evicted)
                        report_mismatch("evicted", 32'(result.evicted), 32'(want.evicted));
                    if (result.evicted_dirty !== want.evicted_dirty)
                        report_mismatch("evicted_dirty", 32'(result.evicted_dirty),
                                        32'(want.evicted_dirty));
                    if (result.evicted_page !== want.evicted_page)
                        report_mismatch("evicted_page", 32'(result.evicted_page),
                                        32'(want.evicted_page));
                    if (result.event_total !== want.event_total)
                        report_mismatch("event_total", result.event_total, want.event_total);
                    if (result.disk_read_total !== want.disk_read_total)
                        report_mismatch("disk_read_total", result.disk_read_total,
                                        want.disk_read_total);
                    if (result.disk_write_total !== want.disk_write_total)
                        report_mismatch("disk_write_total", result.disk_write_total,
                                        want.disk_write_total);
                    hits_seen += int'(want.hit);
                    evictions_seen += int'(want.evicted);
                    writebacks_seen += int'(want.evicted_dirty);
                end
                checked++;
            end
            if (cfg_valid && cfg_ready)
                frame_reg = cfg_data;
            if (start && !busy)
                pending_outcomes.insert(pending_outcomes.size(), predict_access(request));
            if (wrap_up && !wrapped)
            begin
                wrapped = 1'b1;
                foreach (pending_outcomes[i])
                    report_mismatch("result never arrived", 32'd0, 32'd1);
                $display("Checked %0d results: %0d hits, %0d evictions, %0d dirty write-backs.",
                         checked, hits_seen, evictions_seen, writebacks_seen);
            end
        end
        pending <= pending_outcomes.size();
    end

endmodule

>>> dv/tb_lru_page_replacement_tracker_unit.sv
// Testbench top for the LRU page replacement tracker: drives accesses and frame-limit writes.
// Checking is done by lpr_access_checker; this file gives the verdict.
// Depends on lpr_pkg, lpr_access_checker and lru_page_replacement_tracker_unit.
`timescale 1ns / 1ps

module tb_lru_page_replacement_tracker_unit;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    lpr_pkg::request_t request = '0;
    logic              result_valid;
    lpr_pkg::result_t  result;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    lpr_pkg::occ_t     cfg_data = '0;
    logic              wrap_up = 1'b0;
    int                mismatches;
    int                pending;
    int                idle_pct = 0;
    int                sent = 0;
    lpr_pkg::occ_t     frame_plan[12] = '{7'd1, 7'd64, 7'd5, 7'd127, 7'd3, 7'd17,
                                          7'd0, 7'd64, 7'd40, 7'd2, 7'd96, 7'd9};

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    lru_page_replacement_tracker_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    lpr_access_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .wrap_up      (wrap_up),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    task automatic send_access(logic [31:0] addr, logic wr);
        lpr_pkg::request_t req;
        req.byte_address = addr;
        req.is_write = wr;
        start <= 1'b1;
        request <= req;
        do @(posedge clk); while (busy);
        sent++;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_frames(lpr_pkg::occ_t value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(int count, int limit, int pause_at);
        lpr_pkg::page_t page_pool[100];
        int             pool_n;
        logic [31:0]    addr;
        pool_n = limit + $urandom_range(1, limit / 3 + 3);
        if (pool_n > 100)
            pool_n = 100;
        for (int i = 0; i < pool_n; i++)
            case ($urandom_range(9))
                0: page_pool[i] = '0;
                1: page_pool[i] = '1;
                default: page_pool[i] = lpr_pkg::page_t'($urandom);
            endcase
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(9) == 0)
                addr = $urandom;
            else
                addr = {page_pool[$urandom_range(pool_n - 1)], 12'($urandom)};
            send_access(addr, 1'($urandom_range(1)));
            if (n == pause_at)
                wait_idle();
        end
    endtask

    initial
    begin
        #3ms;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int limit;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 29;
        send_access(32'h0000_0000, 1'b0);
        send_access(32'hFFFF_FFFF, 1'b1);
        send_access(32'h0000_0FFF, 1'b0);
        send_access(32'hFFFF_F123, 1'b1);
        send_access(32'h0000_0800, 1'b1);
        send_access(32'h1234_5678, 1'b0);
        send_access(32'hABCD_E000, 1'b0);
        wait_idle();
        write_frames(7'd2);
        send_access(32'h5555_5555, 1'b0);
        send_access(32'hAAAA_AAAA, 1'b1);
        send_access(32'h5555_5000, 1'b1);
        send_access(32'h7777_7777, 1'b0);
        send_access(32'hAAAA_A001, 1'b0);
        wait_idle();
        write_frames(7'd0);
        send_access(32'h0000_0000, 1'b0);
        send_access(32'h0000_0000, 1'b1);
        send_access(32'h0000_1000, 1'b0);
        send_access(32'h0000_1FFF, 1'b1);
        wait_idle();
        write_frames(7'd127);
        send_access(32'h0000_2000, 1'b0);
        send_access(32'h0000_3000, 1'b1);
        send_access(32'h0000_2000, 1'b1);
        send_access(32'h0000_1000, 1'b0);

        foreach (frame_plan[p])
        begin
            idle_pct = (p < 4) ? 29 : ((p < 8) ? 50 : 0);
            wait_idle();
            write_frames(frame_plan[p]);
            limit = (frame_plan[p] == 0) ? 1 :
                    ((frame_plan[p] > lpr_pkg::MAX_FRAMES) ? lpr_pkg::MAX_FRAMES
                                                            : int'(frame_plan[p]));
            run_phase(90, limit, (p == 5) ? 45 : -1);
        end

        wait_idle();
        wrap_up <= 1'b1;
        repeat (2) @(posedge clk);
        $display("Sent %0d accesses across %0d frame-limit settings, with and without gaps.",
                 sent, $size(frame_plan) + 4);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
